// File: rtl/rpf_pkg.sv
// shared types, constants and helper functions for the remote packet failsafe
package rpf_pkg;

  // packet framing and check values
  localparam logic [7:0] HEADER_MARK  = 8'hA5;
  localparam logic [7:0] VERSION_MARK = 8'hC3;
  localparam logic [7:0] CHECK_SEED   = 8'h5A;

  // safety command codes carried in packet byte 6
  localparam logic [7:0] CODE_ESTOP = 8'd1;
  localparam logic [7:0] CODE_ARM   = 8'd2;

  // stick range after clamping
  localparam logic signed [7:0] STICK_MAX = 8'sd100;
  localparam logic signed [7:0] STICK_MIN = -8'sd100;

  // configuration reset values
  localparam logic [7:0]  LOST_LIMIT_RST   = 8'd20;
  localparam logic [6:0]  THROTTLE_MAX_RST = 7'd70;
  localparam logic [14:0] MAX_ROLL_RST     = 15'd1280;
  localparam logic [14:0] MAX_PITCH_RST    = 15'd1280;

  // divide by 100 through a reciprocal: q = (m * DIV_RECIP) >> DIV_SHIFT
  // exact for every m below 2**22 since m * (DIV_RECIP*100 - 2**DIV_SHIFT) < 2**DIV_SHIFT
  localparam int          DIV_SHIFT = 29;
  localparam int          MAG_W     = 22;
  localparam int          RECIP_W   = 23;
  localparam int          QUOT_W    = 15;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 23'd5368710;

  // command queue geometry
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LOST_LIMIT   = 2'd0,
    REG_THROTTLE_MAX = 2'd1,
    REG_MAX_ROLL     = 2'd2,
    REG_MAX_PITCH    = 2'd3
  } reg_index_t;

  // configuration register set
  typedef struct packed {
    logic [7:0]  lost_limit;
    logic [6:0]  throttle_max;
    logic [14:0] max_roll_q8;
    logic [14:0] max_pitch_q8;
  } cfg_t;

  // classified tick passed from front to back
  typedef struct packed {
    logic              pkt_ok;
    logic              estop;
    logic              arm;
    logic signed [7:0] vertical;
    logic signed [7:0] forward;
    logic signed [7:0] lateral;
  } cmd_t;

  // saturate a raw stick to the allowed range
  function automatic logic signed [7:0] clamp_stick(input logic signed [7:0] raw);
    logic signed [7:0] res;
    res = raw;
    if (raw > STICK_MAX) begin
      res = STICK_MAX;
    end else if (raw < STICK_MIN) begin
      res = STICK_MIN;
    end
    return res;
  endfunction

  // unsigned quotient by 100
  function automatic logic [QUOT_W-1:0] div100(input logic [MAG_W-1:0] m);
    logic [MAG_W+RECIP_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, m} * {{MAG_W{1'b0}}, DIV_RECIP};
    return prod[DIV_SHIFT +: QUOT_W];
  endfunction

endpackage

// File: rtl/rpf_front.sv
// front end: checks each tick's packet and clamps the sticks
module rpf_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              received,
  input  logic [7:0]        header_byte,
  input  logic [7:0]        vertical_raw,
  input  logic [7:0]        forward_raw,
  input  logic [7:0]        lateral_raw,
  input  logic [7:0]        spare_byte,
  input  logic [7:0]        check_byte,
  input  logic [7:0]        safety_code,
  input  logic [7:0]        version_byte,
  output logic              push_valid,
  input  logic              push_ready,
  output rpf_pkg::cmd_t     push_cmd
);

  logic [7:0] chk;
  logic       pkt_ok;

  // xor check over every byte but the check byte
  assign chk = rpf_pkg::CHECK_SEED ^ header_byte ^ vertical_raw ^ forward_raw ^
               lateral_raw ^ spare_byte ^ safety_code ^ version_byte;

  assign pkt_ok = received && (header_byte == rpf_pkg::HEADER_MARK) &&
                  (version_byte == rpf_pkg::VERSION_MARK) && (chk == check_byte);

  // classified request toward the queue
  always_comb begin
    push_cmd.pkt_ok   = pkt_ok;
    push_cmd.estop    = (safety_code == rpf_pkg::CODE_ESTOP);
    push_cmd.arm      = (safety_code == rpf_pkg::CODE_ARM);
    push_cmd.vertical = rpf_pkg::clamp_stick(vertical_raw);
    push_cmd.forward  = rpf_pkg::clamp_stick(forward_raw);
    push_cmd.lateral  = rpf_pkg::clamp_stick(lateral_raw);
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// File: rtl/rpf_queue.sv
// two-entry command queue between front and back
module rpf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  rpf_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rpf_pkg::cmd_t pop_cmd
);

  rpf_pkg::cmd_t                entries [rpf_pkg::QDEPTH];
  logic [rpf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rpf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rpf_pkg::QCNT_W-1:0]   count;
  logic                         push;
  logic                         pop;

  assign push_ready = (count != rpf_pkg::QCNT_W'(rpf_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/rpf_back.sv
// back end: link and stop state, then scaling of the stored sticks
module rpf_back (
  input  logic              clk,
  input  logic              rst,
  input  rpf_pkg::cfg_t     cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  rpf_pkg::cmd_t     pop_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              packet_valid,
  output logic [6:0]        throttle,
  output logic signed [7:0] vertical_cmd,
  output logic signed [7:0] forward_cmd,
  output logic signed [7:0] lateral_cmd,
  output logic signed [15:0] roll_target,
  output logic signed [15:0] pitch_target,
  output logic              connected,
  output logic              emergency_stop
);

  // stage a: the state itself, plus a flag for an unconsumed snapshot
  logic              a_valid;
  logic              a_pkt;
  logic signed [7:0] vertical_store, vertical_store_next;
  logic signed [7:0] forward_store, forward_store_next;
  logic signed [7:0] lateral_store, lateral_store_next;
  logic              link_alive, link_alive_next;
  logic [7:0]        lost_count, lost_count_next;
  logic              stop_latch, stop_latch_next;
  logic              a_ready;
  logic              pop;

  // stage b: product magnitudes
  logic                      b_valid;
  logic                      b_ready;
  logic                      b_pkt;
  logic                      b_link;
  logic                      b_stop;
  logic signed [7:0]         b_vert;
  logic signed [7:0]         b_fwd;
  logic signed [7:0]         b_lat;
  logic [13:0]               b_thr_prod;
  logic [rpf_pkg::MAG_W-1:0] b_roll_mag;
  logic                      b_roll_neg;
  logic [rpf_pkg::MAG_W-1:0] b_pitch_mag;
  logic                      b_pitch_neg;

  // stage c helpers
  logic                       c_ready;
  logic [rpf_pkg::QUOT_W-1:0] roll_q;
  logic [rpf_pkg::QUOT_W-1:0] pitch_q;
  logic [rpf_pkg::QUOT_W-1:0] thr_q;

  // stage b helpers
  logic [6:0] lat_mag;
  logic [6:0] fwd_mag;

  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign c_ready   = !out_valid || out_ready;
  assign pop_ready = a_ready;
  assign pop       = pop_valid && a_ready;

  // next state for one request
  always_comb begin
    vertical_store_next = vertical_store;
    forward_store_next  = forward_store;
    lateral_store_next  = lateral_store;
    link_alive_next     = link_alive;
    lost_count_next     = lost_count;
    stop_latch_next     = stop_latch;
    if (pop_cmd.pkt_ok) begin
      lost_count_next = '0;
      link_alive_next = 1'b1;
      if (pop_cmd.estop) begin
        stop_latch_next = 1'b1;
      end else if (pop_cmd.arm && (pop_cmd.vertical == 8'sd0)) begin
        stop_latch_next = 1'b0;
      end
      if (!stop_latch_next) begin
        vertical_store_next = pop_cmd.vertical;
        forward_store_next  = pop_cmd.forward;
        lateral_store_next  = pop_cmd.lateral;
      end
    end else begin
      if (lost_count < cfg.lost_limit) begin
        lost_count_next = lost_count + 8'd1;
      end
      if (lost_count_next >= cfg.lost_limit) begin
        link_alive_next = 1'b0;
        stop_latch_next = 1'b1;
      end
    end
    // a latched stop always leaves the sticks cleared
    if (stop_latch_next) begin
      vertical_store_next = '0;
      forward_store_next  = '0;
      lateral_store_next  = '0;
    end
  end

  // stage a registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      a_pkt          <= 1'b0;
      vertical_store <= '0;
      forward_store  <= '0;
      lateral_store  <= '0;
      link_alive     <= 1'b0;
      lost_count     <= '0;
      stop_latch     <= 1'b1;
    end else begin
      if (pop) begin
        a_valid        <= 1'b1;
        a_pkt          <= pop_cmd.pkt_ok;
        vertical_store <= vertical_store_next;
        forward_store  <= forward_store_next;
        lateral_store  <= lateral_store_next;
        link_alive     <= link_alive_next;
        lost_count     <= lost_count_next;
        stop_latch     <= stop_latch_next;
      end else if (b_ready) begin
        a_valid <= 1'b0;
      end
    end
  end

  // stick magnitudes, at most 100
  assign lat_mag = lateral_store[7] ? 7'(-lateral_store) : lateral_store[6:0];
  assign fwd_mag = forward_store[7] ? 7'(-forward_store) : forward_store[6:0];

  // stage b valid
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  // stage b payload: one multiply per scaled output
  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      b_pkt       <= a_pkt;
      b_link      <= link_alive;
      b_stop      <= stop_latch;
      b_vert      <= vertical_store;
      b_fwd       <= forward_store;
      b_lat       <= lateral_store;
      b_thr_prod  <= (vertical_store > 8'sd0) ?
                     14'(vertical_store[6:0]) * 14'(cfg.throttle_max) : '0;
      b_roll_mag  <= rpf_pkg::MAG_W'(lat_mag) * rpf_pkg::MAG_W'(cfg.max_roll_q8);
      b_roll_neg  <= lateral_store[7];
      b_pitch_mag <= rpf_pkg::MAG_W'(fwd_mag) * rpf_pkg::MAG_W'(cfg.max_pitch_q8);
      b_pitch_neg <= !forward_store[7];
    end
  end

  // divide by 100 through the reciprocal
  assign roll_q  = rpf_pkg::div100(b_roll_mag);
  assign pitch_q = rpf_pkg::div100(b_pitch_mag);
  assign thr_q   = rpf_pkg::div100(rpf_pkg::MAG_W'(b_thr_prod));

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_ready) begin
      out_valid <= b_valid;
    end
  end

  // output payload with signs applied
  always_ff @(posedge clk) begin
    if (b_valid && c_ready) begin
      packet_valid   <= b_pkt;
      throttle       <= thr_q[6:0];
      vertical_cmd   <= b_vert;
      forward_cmd    <= b_fwd;
      lateral_cmd    <= b_lat;
      roll_target    <= b_roll_neg ? -$signed({1'b0, roll_q}) : $signed({1'b0, roll_q});
      pitch_target   <= b_pitch_neg ? -$signed({1'b0, pitch_q}) : $signed({1'b0, pitch_q});
      connected      <= b_link;
      emergency_stop <= b_stop;
    end
  end

endmodule

// File: rtl/remote_packet_failsafe_top.sv
// top level of the remote packet failsafe: configuration registers and block wiring

// Remote control link decoder with emergency stop and lost-link failsafe. Each
// request is one control tick (receive flag plus eight packet bytes) and yields
// exactly one result. One request is taken every clock cycle while the queue has
// room. A taken request goes through the front check into a two-entry queue,
// then the state update stage, the stick multiply stage and the divide-by-100
// stage, which ends in the output register. The output register holds a
// result while the downstream side stalls and the queue absorbs the stages
// behind it, so the input keeps flowing until the queue is full. Configuration
// writes take effect at once and are meant for times when no tick is in flight.
module remote_packet_failsafe_top (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  // tick input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               received,
  input  logic [7:0]         header_byte,
  input  logic [7:0]         vertical_raw,
  input  logic [7:0]         forward_raw,
  input  logic [7:0]         lateral_raw,
  input  logic [7:0]         spare_byte,
  input  logic [7:0]         check_byte,
  input  logic [7:0]         safety_code,
  input  logic [7:0]         version_byte,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic               packet_valid,
  output logic [6:0]         throttle,
  output logic signed [7:0]  vertical_cmd,
  output logic signed [7:0]  forward_cmd,
  output logic signed [7:0]  lateral_cmd,
  output logic signed [15:0] roll_target,
  output logic signed [15:0] pitch_target,
  output logic               connected,
  output logic               emergency_stop
);

  rpf_pkg::cfg_t cfg;
  logic          push_valid;
  logic          push_ready;
  rpf_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop_ready;
  rpf_pkg::cmd_t pop_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lost_limit   <= rpf_pkg::LOST_LIMIT_RST;
      cfg.throttle_max <= rpf_pkg::THROTTLE_MAX_RST;
      cfg.max_roll_q8  <= rpf_pkg::MAX_ROLL_RST;
      cfg.max_pitch_q8 <= rpf_pkg::MAX_PITCH_RST;
    end else if (cfg_write) begin
      case (rpf_pkg::reg_index_t'(cfg_index))
        rpf_pkg::REG_LOST_LIMIT:   cfg.lost_limit   <= cfg_data[7:0];
        rpf_pkg::REG_THROTTLE_MAX: cfg.throttle_max <= cfg_data[6:0];
        rpf_pkg::REG_MAX_ROLL:     cfg.max_roll_q8  <= cfg_data;
        rpf_pkg::REG_MAX_PITCH:    cfg.max_pitch_q8 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // packet check and stick clamp
  rpf_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .received     (received),
    .header_byte  (header_byte),
    .vertical_raw (vertical_raw),
    .forward_raw  (forward_raw),
    .lateral_raw  (lateral_raw),
    .spare_byte   (spare_byte),
    .check_byte   (check_byte),
    .safety_code  (safety_code),
    .version_byte (version_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  // decoupling queue
  rpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // state update and scaling
  rpf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_cmd        (pop_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .packet_valid   (packet_valid),
    .throttle       (throttle),
    .vertical_cmd   (vertical_cmd),
    .forward_cmd    (forward_cmd),
    .lateral_cmd    (lateral_cmd),
    .roll_target    (roll_target),
    .pitch_target   (pitch_target),
    .connected      (connected),
    .emergency_stop (emergency_stop)
  );

`ifndef NO_ASSERTIONS
  // a latched stop never lets a command through
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && emergency_stop |-> throttle == 7'd0 && vertical_cmd == 8'sd0 &&
      forward_cmd == 8'sd0 && lateral_cmd == 8'sd0 &&
      roll_target == 16'sd0 && pitch_target == 16'sd0)
    else $error("commands not cleared while stopped");

  // a dropped link always comes with the stop latched
  a_link_loss_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && !connected |-> emergency_stop)
    else $error("link down without emergency stop");

  // a good packet always marks the link alive
  a_valid_connects: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_valid |-> connected)
    else $error("valid packet but link not connected");
`endif

endmodule
